FILE: src/lifc_pkg.sv
`timescale 1ns / 1ps

package lifc_pkg;

  // fnv-1a 64-bit
  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // magic "MIDXV1" then two zero bytes, first byte in the low bits
  localparam logic [63:0] MAGIC_WORD = 64'h0000_3156_5844_494D;

  localparam int TAIL_BYTES   = 8;
  localparam int HEADER_BYTES = 16;
  localparam int REC_BITS     = 40;

  // byte classes
  localparam logic [2:0] KIND_MAGIC = 3'd0;
  localparam logic [2:0] KIND_COUNT = 3'd1;
  localparam logic [2:0] KIND_KLEN  = 3'd2;
  localparam logic [2:0] KIND_VLEN  = 3'd3;
  localparam logic [2:0] KIND_KEY   = 3'd4;
  localparam logic [2:0] KIND_VALUE = 3'd5;
  localparam logic [2:0] KIND_TRAIL = 3'd6;

  // final status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CHECKSUM  = 3'd2;
  localparam logic [2:0] ST_MAGIC     = 3'd3;
  localparam logic [2:0] ST_COUNT     = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;
  localparam logic [2:0] ST_TRAILING  = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                byte_valid;
    logic [7:0]          body_byte;
    logic [2:0]          byte_kind;
    logic [REC_BITS-1:0] record_index;
    logic                record_done;
    logic                file_done;
    logic [2:0]          status;
  } out_item_t;

  // delay line view handed to the parser
  typedef struct packed {
    logic        released;
    logic [7:0]  leaving;
    logic [63:0] stored;
    logic        full;
  } tail_info_t;

  // xor then multiply by the prime 2^40 + 0x1b3, as shifts and adds
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

FILE: src/lifc_tail.sv
`timescale 1ns / 1ps

module lifc_tail import lifc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_item_t   item,
  output tail_info_t info
);

  localparam logic [3:0] FILL_FULL = 4'(TAIL_BYTES);

  logic [7:0] delay      [TAIL_BYTES];
  logic [7:0] delay_next [TAIL_BYTES];
  logic [3:0] fill;
  logic       released;

  assign released = (fill == FILL_FULL);

  always_comb begin
    delay_next = delay;
    if (released) begin
      for (int i = 0; i < TAIL_BYTES - 1; i++) begin
        delay_next[i] = delay[i + 1];
      end
      delay_next[TAIL_BYTES - 1] = item.data_byte;
    end else begin
      delay_next[fill[2:0]] = item.data_byte;
    end
  end

  always_comb begin
    info.released = released;
    info.leaving  = delay[0];
    info.full     = released || (fill == FILL_FULL - 4'd1);
    for (int i = 0; i < TAIL_BYTES; i++) begin
      info.stored[8*i +: 8] = delay_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        fill <= '0;
      end else if (!released) begin
        fill <= fill + 4'd1;
      end
    end
  end

  // data bytes are only read once written, no reset
  always_ff @(posedge clk) begin
    if (step) begin
      delay <= delay_next;
    end
  end

endmodule

FILE: src/lifc_parse.sv
`timescale 1ns / 1ps

module lifc_parse import lifc_pkg::*; #(
  parameter int LENGTH_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  in_item_t   item,
  input  tail_info_t tail,
  output out_item_t  result
);

  typedef enum logic [2:0] {
    PH_MAGIC, PH_COUNT, PH_KLEN, PH_VLEN, PH_KEY, PH_VALUE, PH_TRAIL
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] HEADER_LEN = LENGTH_BITS'(HEADER_BYTES);

  phase_t                  phase, phase_next;
  logic [2:0]              pos, pos_next;
  logic [63:0]             gather, gather_next, gathered;
  logic [63:0]             rec_total, rec_total_next;
  logic [63:0]             rec_left, rec_left_next;
  logic [31:0]             key_left, key_left_next, key_dec;
  logic [31:0]             value_left, value_left_next, value_dec;
  logic [REC_BITS-1:0]     rec_num, rec_num_next;
  logic                    magic_bad, magic_bad_next;
  logic [63:0]             hash, hash_next;
  logic [LENGTH_BITS-1:0]  body_len, body_len_next;
  logic [2:0]              kind;
  logic                    finish;
  logic [2:0]              status;

  assign gathered  = gather | ({56'd0, tail.leaving} << {pos, 3'b000});
  assign key_dec   = (key_left != '0) ? key_left - 32'd1 : key_left;
  assign value_dec = (value_left != '0) ? value_left - 32'd1 : value_left;

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    gather_next     = gather;
    rec_total_next  = rec_total;
    rec_left_next   = rec_left;
    key_left_next   = key_left;
    value_left_next = value_left;
    rec_num_next    = rec_num;
    magic_bad_next  = magic_bad;
    hash_next       = hash;
    body_len_next   = body_len;
    kind            = KIND_MAGIC;
    finish          = 1'b0;
    if (tail.released) begin
      hash_next = fnv_step(hash, tail.leaving);
      if (!(&body_len)) begin
        body_len_next = body_len + 1'b1;
      end
      case (phase)
        PH_MAGIC: begin
          kind = KIND_MAGIC;
          if (tail.leaving != MAGIC_WORD[{pos, 3'b000} +: 8]) begin
            magic_bad_next = 1'b1;
          end
          if (pos == 3'd7) begin
            pos_next   = '0;
            phase_next = PH_COUNT;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
        PH_COUNT: begin
          kind = KIND_COUNT;
          if (pos == 3'd7) begin
            rec_total_next = gathered;
            rec_left_next  = gathered;
            gather_next    = '0;
            pos_next       = '0;
            phase_next     = (gathered != '0) ? PH_KLEN : PH_TRAIL;
          end else begin
            gather_next = gathered;
            pos_next    = pos + 3'd1;
          end
        end
        PH_KLEN: begin
          kind = KIND_KLEN;
          if (pos >= 3'd3) begin
            key_left_next = gathered[31:0];
            gather_next   = '0;
            pos_next      = '0;
            phase_next    = PH_VLEN;
          end else begin
            gather_next = gathered;
            pos_next    = pos + 3'd1;
          end
        end
        PH_VLEN: begin
          kind = KIND_VLEN;
          if (pos >= 3'd3) begin
            value_left_next = gathered[31:0];
            gather_next     = '0;
            pos_next        = '0;
            if (key_left != '0) begin
              phase_next = PH_KEY;
            end else if (gathered[31:0] != '0) begin
              phase_next = PH_VALUE;
            end else begin
              finish = 1'b1;
            end
          end else begin
            gather_next = gathered;
            pos_next    = pos + 3'd1;
          end
        end
        PH_KEY: begin
          kind          = KIND_KEY;
          key_left_next = key_dec;
          if (key_dec == '0) begin
            if (value_left != '0) begin
              phase_next = PH_VALUE;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_VALUE: begin
          kind            = KIND_VALUE;
          value_left_next = value_dec;
          if (value_dec == '0) begin
            finish = 1'b1;
          end
        end
        default: begin
          kind       = KIND_TRAIL;
          phase_next = PH_TRAIL;
          pos_next   = 3'd1;
        end
      endcase
      if (finish) begin
        rec_left_next = rec_left - 64'd1;
        rec_num_next  = rec_num + 1'b1;
        pos_next      = '0;
        gather_next   = '0;
        phase_next    = (rec_left != 64'd1) ? PH_KLEN : PH_TRAIL;
      end
    end
  end

  // precedence: short, checksum, magic, count, truncated, trailing
  always_comb begin
    if (!tail.full || body_len_next < HEADER_LEN) begin
      status = ST_SHORT;
    end else if (tail.stored != hash_next) begin
      status = ST_CHECKSUM;
    end else if (magic_bad_next) begin
      status = ST_MAGIC;
    end else if (rec_total_next > 64'(body_len_next)) begin
      status = ST_COUNT;
    end else if (phase_next != PH_TRAIL) begin
      status = ST_TRUNCATED;
    end else if (pos_next != '0) begin
      status = ST_TRAILING;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result.byte_valid   = tail.released;
    result.body_byte    = tail.released ? tail.leaving : 8'd0;
    result.byte_kind    = tail.released ? kind : KIND_MAGIC;
    result.record_index = tail.released ? rec_num : '0;
    result.record_done  = tail.released && finish;
    result.file_done    = item.last_byte;
    result.status       = item.last_byte ? status : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase      <= PH_MAGIC;
      pos        <= '0;
      gather     <= '0;
      rec_total  <= '0;
      rec_left   <= '0;
      key_left   <= '0;
      value_left <= '0;
      rec_num    <= '0;
      magic_bad  <= 1'b0;
      hash       <= FNV_BASIS;
      body_len   <= '0;
    end else if (step) begin
      phase      <= phase_next;
      pos        <= pos_next;
      gather     <= gather_next;
      rec_total  <= rec_total_next;
      rec_left   <= rec_left_next;
      key_left   <= key_left_next;
      value_left <= value_left_next;
      rec_num    <= rec_num_next;
      magic_bad  <= magic_bad_next;
      hash       <= hash_next;
      body_len   <= body_len_next;
    end
  end

endmodule

FILE: src/legacy_index_file_checker_core.sv
`timescale 1ns / 1ps

// legacy index file checker
// in channel: one file byte per request (in_data.data_byte), in_data.last_byte
//   high on the final byte of the file
// out channel: one result per body byte leaving the eight-byte tail delay; the
//   result on the last byte of the file also carries file_done and the final status
// the last eight file bytes are the stored fnv-1a 64-bit checksum, little
//   endian; they are held back in the delay and never hashed or classified
// an accepted request lands in the input register; its result, if any, is
//   loaded into the output register once that register is free
// throughput: one request per cycle unless the receiver stalls, limited by the
//   hash update (xor, then shifts and adds for the prime) between the two registers
// a stalled receiver holds the output register; the input register still
//   takes one more request, then in_ready drops until out_ready returns
// reset clears both registers' valid flags and puts the delay, hash, length
//   counter and parser in their start state; the last byte of every file puts
//   those four back in it too, so files can follow back to back
module legacy_index_file_checker_core import lifc_pkg::*; #(
  parameter int LENGTH_BITS = 40
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  in_item_t   in_hold;      // input register payload
  logic       in_full;      // input register holds a request
  logic       out_free;     // output register can take a result this cycle
  logic       step;         // the held request is processed this cycle
  logic       produce;      // the held request yields a result
  tail_info_t tail_info;
  out_item_t  result;

  assign out_free = !out_valid || out_ready;
  assign step     = in_full && out_free;
  assign in_ready = !in_full || out_free;
  assign produce  = tail_info.released || in_hold.last_byte;

  // tail delay line
  lifc_tail u_tail (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_hold),
    .info (tail_info)
  );

  // hash, length counter, record parser and final status
  lifc_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_hold),
    .tail   (tail_info),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (step && produce) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_data;
    end
    if (step && produce) begin
      out_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // every result carries a body byte or closes a file
  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.byte_valid || out_data.file_done))
    else $error("result with neither body byte nor file end");

  // no body byte means zeroed byte fields
  a_empty_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_valid) |->
      (out_data.body_byte == 8'd0 && out_data.record_index == '0 &&
       !out_data.record_done && out_data.byte_kind == KIND_MAGIC))
    else $error("fields set on a result without a body byte");

  // status only reported at file end
  a_status_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.file_done) |-> out_data.status == ST_OK)
    else $error("status reported before the end of the file");

  // header bytes always belong to record zero
  a_header_record_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.byte_valid &&
     (out_data.byte_kind == KIND_MAGIC || out_data.byte_kind == KIND_COUNT))
      |-> out_data.record_index == '0)
    else $error("header byte tagged with a nonzero record");

  // a record completes only on a length or content byte
  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.record_done) |->
      (out_data.byte_kind == KIND_VLEN || out_data.byte_kind == KIND_KEY ||
       out_data.byte_kind == KIND_VALUE))
    else $error("record completed on an unexpected byte class");
`endif

endmodule

FILE: sim/legacy_index_file_checker_core_tb.sv
`timescale 1ns / 1ps

// self-checking bench for the legacy index file checker
// whole index files are built here (magic, count, records, fnv-1a checksum),
// sent one byte per request, and every result is compared with a local
// predictor that tracks the delay line, hash, length counter and parser
module legacy_index_file_checker_core_tb;
  import lifc_pkg::*;

  localparam int          LENGTH_BITS  = 40;
  localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
  localparam logic [63:0] LEN_MAX      = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    P_MAGIC, P_COUNT, P_KLEN, P_VLEN, P_KEY, P_VALUE, P_TRAIL
  } parse_state_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  legacy_index_file_checker_core #(.LENGTH_BITS(LENGTH_BITS)) u_top (
    .clk,
    .rst,
    .in_valid,
    .in_ready,
    .in_data,
    .out_valid,
    .out_ready,
    .out_data
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state: mirrors the block's delay line and parser
  logic [7:0]          tail_q [8];
  int unsigned         tail_cnt;
  logic [63:0]         running_hash;
  logic [63:0]         body_len;
  parse_state_t        parse_state;
  int unsigned         field_pos;
  logic [63:0]         gather;
  logic [63:0]         rec_total;
  logic [63:0]         rec_left;
  logic [31:0]         key_left;
  logic [31:0]         val_left;
  logic [REC_BITS-1:0] rec_num;
  logic                magic_err;

  out_item_t   expected_results[$];
  out_item_t   want;
  logic [7:0]  file_bytes[$];

  int          send_idle_pct = 7;
  int          recv_idle_pct = 51;
  int          stall_req = 0;
  int          stall_left = 0;
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          files_sent = 0;
  int          results_seen = 0;
  int          cycle_count = 0;
  logic [6:0]  status_seen = '0;

  task automatic clear_state();
    foreach (tail_q[i]) tail_q[i] = 8'h00;
    tail_cnt     = 0;
    running_hash = FNV_BASIS;
    body_len     = '0;
    parse_state  = P_MAGIC;
    field_pos    = 0;
    gather       = '0;
    rec_total    = '0;
    rec_left     = '0;
    key_left     = '0;
    val_left     = '0;
    rec_num      = '0;
    magic_err    = 1'b0;
  endtask

  // expected result (if any) of one accepted file byte
  task automatic predict_byte(input logic [7:0] b, input logic last);
    out_item_t   r;
    logic        released;
    logic        record_end;
    logic [7:0]  leaving;
    logic [63:0] stored;
    r          = '0;
    record_end = 1'b0;
    released   = (tail_cnt >= TAIL_BYTES);
    leaving    = tail_q[0];
    if (released) begin
      for (int i = 0; i < 7; i++) tail_q[i] = tail_q[i + 1];
      tail_q[7] = b;
    end else begin
      tail_q[tail_cnt] = b;
      tail_cnt++;
    end
    // still filling the delay line and not the end of file: nothing comes out
    if (!released && !last) return;

    if (released) begin
      r.byte_valid   = 1'b1;
      r.body_byte    = leaving;
      r.record_index = rec_num;
      running_hash   = (running_hash ^ {56'd0, leaving}) * FNV_PRIME;
      if (body_len < LEN_MAX) body_len++;
      case (parse_state)
        P_MAGIC: begin
          r.byte_kind = KIND_MAGIC;
          if (leaving != MAGIC_WORD[8 * field_pos +: 8]) magic_err = 1'b1;
          if (field_pos == 7) begin
            field_pos   = 0;
            parse_state = P_COUNT;
          end else begin
            field_pos++;
          end
        end
        P_COUNT: begin
          r.byte_kind = KIND_COUNT;
          gather |= {56'd0, leaving} << (8 * field_pos);
          if (field_pos == 7) begin
            rec_total   = gather;
            rec_left    = gather;
            gather      = '0;
            field_pos   = 0;
            parse_state = (rec_left != 0) ? P_KLEN : P_TRAIL;
          end else begin
            field_pos++;
          end
        end
        P_KLEN: begin
          r.byte_kind = KIND_KLEN;
          gather |= {56'd0, leaving} << (8 * field_pos);
          if (field_pos == 3) begin
            key_left    = gather[31:0];
            gather      = '0;
            field_pos   = 0;
            parse_state = P_VLEN;
          end else begin
            field_pos++;
          end
        end
        P_VLEN: begin
          r.byte_kind = KIND_VLEN;
          gather |= {56'd0, leaving} << (8 * field_pos);
          if (field_pos == 3) begin
            val_left  = gather[31:0];
            gather    = '0;
            field_pos = 0;
            if (key_left != 0) parse_state = P_KEY;
            else if (val_left != 0) parse_state = P_VALUE;
            else record_end = 1'b1;
          end else begin
            field_pos++;
          end
        end
        P_KEY: begin
          r.byte_kind = KIND_KEY;
          if (key_left != 0) key_left--;
          if (key_left == 0) begin
            if (val_left != 0) parse_state = P_VALUE;
            else record_end = 1'b1;
          end
        end
        P_VALUE: begin
          r.byte_kind = KIND_VALUE;
          if (val_left != 0) val_left--;
          if (val_left == 0) record_end = 1'b1;
        end
        default: begin
          // any byte past the last record marks the file as having trailing bytes
          r.byte_kind = KIND_TRAIL;
          parse_state = P_TRAIL;
          field_pos   = 1;
        end
      endcase
      if (record_end) begin
        r.record_done = 1'b1;
        rec_left--;
        rec_num++;
        field_pos   = 0;
        gather      = '0;
        parse_state = (rec_left != 0) ? P_KLEN : P_TRAIL;
      end
    end

    if (last) begin
      // the eight held-back bytes are the stored checksum, little endian
      stored = {tail_q[7], tail_q[6], tail_q[5], tail_q[4],
                tail_q[3], tail_q[2], tail_q[1], tail_q[0]};
      r.file_done = 1'b1;
      if (tail_cnt < TAIL_BYTES || body_len < HEADER_BYTES) r.status = ST_SHORT;
      else if (stored != running_hash)                      r.status = ST_CHECKSUM;
      else if (magic_err)                                   r.status = ST_MAGIC;
      else if (rec_total > body_len)                        r.status = ST_COUNT;
      else if (parse_state != P_TRAIL)                      r.status = ST_TRUNCATED;
      else if (field_pos != 0)                              r.status = ST_TRAILING;
      else                                                  r.status = ST_OK;
      clear_state();
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  // one request on the input channel; valid only drops when a gap is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    predict_byte(b, last);
  endtask

  // file building helpers
  task automatic add_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic start_index(input logic [63:0] count);
    file_bytes.delete();
    for (int i = 0; i < 8; i++) add_byte(MAGIC_WORD[8 * i +: 8]);
    for (int i = 0; i < 8; i++) add_byte(count[8 * i +: 8]);
  endtask

  task automatic add_u32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8 * i +: 8]);
  endtask

  task automatic add_random(input int unsigned n);
    repeat (n) add_byte(8'($urandom_range(255)));
  endtask

  task automatic add_record(input int unsigned klen, input int unsigned vlen);
    add_u32(klen);
    add_u32(vlen);
    add_random(klen + vlen);
  endtask

  // append the fnv-1a checksum of everything so far
  task automatic seal_index();
    logic [63:0] h;
    h = FNV_BASIS;
    foreach (file_bytes[i]) h = (h ^ {56'd0, file_bytes[i]}) * FNV_PRIME;
    for (int i = 0; i < 8; i++) add_byte(h[8 * i +: 8]);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    files_sent++;
  endtask

  function automatic int unsigned rand_len();
    return ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(6);
  endfunction

  // result checking
  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %0h", out_data);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        results_seen++;
        check_field("byte_valid", 64'(want.byte_valid), 64'(out_data.byte_valid));
        check_field("body_byte", 64'(want.body_byte), 64'(out_data.body_byte));
        check_field("byte_kind", 64'(want.byte_kind), 64'(out_data.byte_kind));
        check_field("record_index", 64'(want.record_index),
                    64'(out_data.record_index));
        check_field("record_done", 64'(want.record_done), 64'(out_data.record_done));
        check_field("file_done", 64'(want.file_done), 64'(out_data.file_done));
        check_field("status", 64'(want.status), 64'(out_data.status));
        if (want.file_done) status_seen[want.status] = 1'b1;
      end
    end
  end

  // receiver: random back-pressure, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // too few bytes to hold header and checksum
  task automatic test_short_files();
    int unsigned sizes[4] = '{1, 8, 9, 23};
    foreach (sizes[i]) begin
      file_bytes.delete();
      add_random(sizes[i]);
      send_file();
    end
  endtask

  // smallest valid file: header with zero records, exactly 24 bytes
  task automatic test_empty_index();
    start_index(64'd0);
    seal_index();
    send_file();
  endtask

  // empty key and value, key only, value only, extreme content bytes
  task automatic test_record_shapes();
    start_index(64'd5);
    add_record(0, 0);
    add_record(3, 0);
    add_record(0, 2);
    add_record(1, 1);
    add_u32(32'd2);
    add_u32(32'd2);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'h00);
    seal_index();
    send_file();
  endtask

  task automatic test_checksum_error();
    start_index(64'd1);
    add_record(2, 1);
    seal_index();
    file_bytes[file_bytes.size() - 1] ^= 8'h80;
    send_file();
  endtask

  // bad magic with a correct checksum, in a letter and in a pad byte
  task automatic test_bad_magic();
    start_index(64'd0);
    file_bytes[3] ^= 8'h20;
    seal_index();
    send_file();
    start_index(64'd1);
    file_bytes[6] = 8'h58;
    add_record(1, 2);
    seal_index();
    send_file();
  endtask

  // count above body length; the boundary count equal to body length is only truncated
  task automatic test_impossible_count();
    start_index(64'hFFFF_FFFF_FFFF_FFFF);
    add_record(1, 1);
    seal_index();
    send_file();
    start_index(64'd17);
    seal_index();
    send_file();
    start_index(64'd16);
    seal_index();
    send_file();
  endtask

  task automatic test_truncated();
    start_index(64'd2);
    add_record(2, 2);
    seal_index();
    send_file();
    start_index(64'd1);
    add_u32(32'hFFFF_FFFF);
    add_u32(32'hFFFF_FFFF);
    add_random(3);
    seal_index();
    send_file();
  endtask

  task automatic test_trailing();
    start_index(64'd1);
    add_record(1, 3);
    add_random(2);
    seal_index();
    send_file();
    start_index(64'd0);
    add_random(1);
    seal_index();
    send_file();
  endtask

  // long receiver hold-off while the sender keeps offering bytes
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    start_index(64'd2);
    add_record(20, 20);
    add_record(10, 5);
    seal_index();
    stall_req = 150;
    send_file();
  endtask

  // mostly well-formed files with random content, the rest broken or noise
  task automatic test_random_files(input int target, input int send_pct, input int recv_pct);
    int unsigned stop_at;
    int unsigned mode;
    int unsigned nrec;
    int unsigned k;
    int unsigned v;
    logic [63:0] count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      mode  = $urandom_range(99);
      nrec  = $urandom_range(4);
      count = 64'(nrec);
      if (mode >= 80 && mode < 86) count = 64'(nrec + 1);
      else if (mode >= 86 && mode < 90) count = {$urandom, $urandom} >> $urandom_range(63);
      start_index(count);
      repeat (nrec) add_record(rand_len(), rand_len());
      // cut the last record short
      if (mode >= 80 && mode < 86) begin
        k = rand_len();
        v = rand_len();
        add_record(k, v);
        repeat ($urandom_range(1, 8 + k + v)) void'(file_bytes.pop_back());
      end
      if (mode >= 90 && mode < 95) add_random($urandom_range(1, 6));
      if (mode >= 70 && mode < 75) file_bytes[$urandom_range(7)] ^= 8'h01 << $urandom_range(7);
      seal_index();
      if (mode >= 75 && mode < 80)
        file_bytes[$urandom_range(file_bytes.size() - 1)] ^= 8'h01 << $urandom_range(7);
      if (mode >= 95) begin
        file_bytes.delete();
        add_random($urandom_range(1, 40));
      end
      send_file();
    end
  endtask

  initial begin
    clear_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_short_files();
    test_empty_index();
    test_record_shapes();
    test_checksum_error();
    test_bad_magic();
    test_impossible_count();
    test_truncated();
    test_trailing();
    test_output_stall();
    test_random_files(310, 7, 51);
    test_random_files(310, 51, 7);
    test_random_files(310, 0, 0);
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d files, %0d bytes, %0d results checked",
             files_sent, bytes_sent, results_seen);
    $display("final status codes seen (bit per code): %b", status_seen);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
